// ===== design/erdc_pkg.sv =====
package erdc_pkg;

    // Ring geometry
    localparam int RING_SIZE = 256;
    localparam int HEAD_W    = $clog2(RING_SIZE);
    localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(RING_SIZE - 1);

    // Entry type codes (control bits 15:10)
    localparam logic [5:0] TYPE_TRANSFER = 6'd32;
    localparam logic [5:0] TYPE_CMD_DONE = 6'd33;
    localparam logic [5:0] TYPE_PORT     = 6'd34;
    localparam logic [5:0] TYPE_HOST_ERR = 6'd37;

    // Input item modes
    localparam logic MODE_ENTRY = 1'b0;
    localparam logic MODE_POST  = 1'b1;

    typedef enum logic [3:0] {
        KIND_NOT_OWNED    = 4'd0,
        KIND_CMD_DONE     = 4'd1,
        KIND_TRANSFER     = 4'd2,
        KIND_PORT         = 4'd3,
        KIND_IGNORED      = 4'd4,
        KIND_CMD_MISMATCH = 4'd5,
        KIND_BAD_PORT     = 4'd6,
        KIND_HOST_ERROR   = 4'd7,
        KIND_OFFLINE      = 4'd8,
        KIND_CMD_POSTED   = 4'd9
    } kind_t;

    typedef struct packed {
        logic        mode;
        logic [63:0] entry_parameter;
        logic [31:0] entry_status;
        logic [31:0] entry_control;
        logic [63:0] posted_command;
    } in_item_t;

    typedef struct packed {
        logic        owned;
        kind_t       event_kind;
        logic [7:0]  completion_code;
        logic [7:0]  slot_number;
        logic [7:0]  port_number;
        logic [63:0] forwarded_parameter;
        logic [31:0] forwarded_status;
        logic [7:0]  dequeue_index;
        logic        consumer_cycle;
        logic        online_flag;
    } out_item_t;

    // Consumer state shared between the state holder and the classifier
    typedef struct packed {
        logic [HEAD_W-1:0] head_index;
        logic              cycle_state;
        logic [63:0]       pending_command;
        logic              online;
    } ring_state_t;

endpackage

// ===== design/erdc_state.sv =====
module erdc_state (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [7:0]             cfg_data,
    input  logic                   update,
    input  erdc_pkg::ring_state_t  state_next,
    output erdc_pkg::ring_state_t  state,
    output logic [7:0]             port_count
);

    erdc_pkg::ring_state_t state_reg;
    logic [7:0]            port_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.head_index      <= '0;
            state_reg.cycle_state     <= 1'b1;
            state_reg.pending_command <= '0;
            state_reg.online          <= 1'b1;
        end
        else if (update)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            port_count_reg <= cfg_data;
        end
    end

    assign state      = state_reg;
    assign port_count = port_count_reg;

endmodule

// ===== design/erdc_classify.sv =====
module erdc_classify (
    input  erdc_pkg::in_item_t     item,
    input  erdc_pkg::ring_state_t  state,
    input  logic [7:0]             port_count,
    output erdc_pkg::ring_state_t  state_next,
    output erdc_pkg::out_item_t    result
);

    logic [5:0] entry_type;
    logic [7:0] port;
    logic       cycle_match;

    assign entry_type  = item.entry_control[15:10];
    assign port        = item.entry_parameter[31:24];
    assign cycle_match = (item.entry_control[0] == state.cycle_state);

    always_comb
    begin
        state_next = state;
        result     = '0;
        result.event_kind = erdc_pkg::KIND_NOT_OWNED;

        if (!state.online)
        begin
            result.event_kind = erdc_pkg::KIND_OFFLINE;
        end
        else if (item.mode == erdc_pkg::MODE_POST)
        begin
            state_next.pending_command = item.posted_command;
            result.event_kind          = erdc_pkg::KIND_CMD_POSTED;
        end
        else if (cycle_match)
        begin
            result.owned = 1'b1;
            // Advance the head; wrap toggles the consumer cycle
            if (state.head_index == erdc_pkg::HEAD_LAST)
            begin
                state_next.head_index  = '0;
                state_next.cycle_state = ~state.cycle_state;
            end
            else
            begin
                state_next.head_index = state.head_index + erdc_pkg::HEAD_W'(1);
            end

            case (entry_type)
                erdc_pkg::TYPE_CMD_DONE:
                begin
                    if (state.pending_command == '0 ||
                        item.entry_parameter != state.pending_command)
                    begin
                        state_next.online = 1'b0;
                        result.event_kind = erdc_pkg::KIND_CMD_MISMATCH;
                    end
                    else
                    begin
                        state_next.pending_command = '0;
                        result.event_kind          = erdc_pkg::KIND_CMD_DONE;
                        result.completion_code     = item.entry_status[31:24];
                        result.slot_number         = item.entry_control[31:24];
                    end
                end
                erdc_pkg::TYPE_TRANSFER:
                begin
                    result.event_kind          = erdc_pkg::KIND_TRANSFER;
                    result.forwarded_parameter = item.entry_parameter;
                    result.forwarded_status    = item.entry_status;
                end
                erdc_pkg::TYPE_PORT:
                begin
                    result.port_number = port;
                    if (port == 8'd0 || port > port_count)
                    begin
                        state_next.online = 1'b0;
                        result.event_kind = erdc_pkg::KIND_BAD_PORT;
                    end
                    else
                    begin
                        result.event_kind = erdc_pkg::KIND_PORT;
                    end
                end
                erdc_pkg::TYPE_HOST_ERR:
                begin
                    state_next.online = 1'b0;
                    result.event_kind = erdc_pkg::KIND_HOST_ERROR;
                end
                default:
                begin
                    result.event_kind = erdc_pkg::KIND_IGNORED;
                end
            endcase
        end

        result.dequeue_index  = 8'(state_next.head_index);
        result.consumer_cycle = state_next.cycle_state;
        result.online_flag    = state_next.online;
    end

endmodule

// ===== design/event_ring_dequeue_classifier.sv =====
// Event ring consumer: takes one beat per cycle unless the result side stalls.
// Each beat is held in the input register, then classified into the result register.
// Throughput: one beat per cycle when out_ready does not hold off; the head, cycle and
// pending-command update is a loop from the state registers through the classify logic.
// Reset (rst_n low, async): head 0, cycle 1, no command pending, online, port_count 0,
// both pipeline registers empty.
module event_ring_dequeue_classifier (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write: port_count
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data,
    // ring entry / command post beats
    input  logic                 in_valid,
    output logic                 in_ready,
    input  erdc_pkg::in_item_t   in_data,
    // classified results
    output logic                 out_valid,
    input  logic                 out_ready,
    output erdc_pkg::out_item_t  out_data
);

    logic                  in_valid_reg;
    erdc_pkg::in_item_t    in_data_reg;
    logic                  out_valid_reg;
    erdc_pkg::out_item_t   out_data_reg;

    erdc_pkg::ring_state_t state;
    erdc_pkg::ring_state_t state_next;
    erdc_pkg::out_item_t   result;
    logic [7:0]            port_count;

    logic out_free;   // result register can take a new beat this cycle
    logic advance;    // input register moves into the result register

    // User must write configuration only while idle; the block never checks, always accepts.
    assign cfg_ready = 1'b1;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    // Input register frees up whenever its beat moves on in the same cycle.
    assign in_ready = !in_valid_reg || out_free;

    // Input register: hold the beat until it can be classified and retired.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // Consumer state and port_count. State commits exactly when the beat in the
    // input register is classified into the result register, so the next beat
    // always sees the updated head and cycle.
    erdc_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .update     (advance),
        .state_next (state_next),
        .state      (state),
        .port_count (port_count)
    );

    // Ownership check, head advance and type classification.
    erdc_classify u_classify (
        .item       (in_data_reg),
        .state      (state),
        .port_count (port_count),
        .state_next (state_next),
        .result     (result)
    );

    // Result register: hold until the consumer takes the beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== verif/event_ring_dequeue_classifier_tb.sv =====
`timescale 1ns / 100ps

module event_ring_dequeue_classifier_tb;

    import erdc_pkg::*;

    // Cycles without any beat on any channel before the run is declared hung
    localparam int IDLE_LIMIT  = 2000;
    // Pipeline has an input and a result register; leave a little margin after the last result
    localparam int DRAIN_TICKS = 4;
    // Percentage of cycles in which each side holds off
    localparam int STALL_PCT   = 9;

    // Shapes of generated ring beats
    typedef enum int {
        GEN_POST,
        GEN_DONE,
        GEN_TRANSFER,
        GEN_PORT,
        GEN_OTHER,
        GEN_STALE
    } entry_pick_t;

    // Ways to take the block offline; only one can happen per run
    typedef enum int {
        FATAL_ADDR_MISMATCH,
        FATAL_NO_COMMAND,
        FATAL_PORT_ZERO,
        FATAL_PORT_ABOVE,
        FATAL_HOST_ERROR
    } fatal_pick_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [7:0] cfg_data = '0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // Mirror of the consumer state, updated at each accepted input beat
    int unsigned ring_head;
    logic        ring_cycle;
    logic [63:0] ring_pending;
    logic        ring_online;
    logic [7:0]  ring_ports;

    // Classified results still owed by the block, oldest first
    out_item_t   predicted_events[$];

    int unsigned mismatch_count = 0;
    int unsigned beats_in       = 0;
    int unsigned beats_out      = 0;
    int unsigned idle_cycles    = 0;
    int unsigned kind_tally[10] = '{default: 0};
    // When set, neither side holds off
    bit          steady         = 1'b0;

    event_ring_dequeue_classifier DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Advance the mirrored ring state by one input beat and return the result it owes.
    function automatic out_item_t classify_entry(input in_item_t item);
        out_item_t  res;
        logic [5:0] etype;
        logic [7:0] port;
        res   = '0;
        etype = item.entry_control[15:10];
        port  = item.entry_parameter[31:24];
        if (!ring_online)
        begin
            // offline is sticky: nothing moves until reset
            res.event_kind = KIND_OFFLINE;
        end
        else if (item.mode == MODE_POST)
        begin
            ring_pending   = item.posted_command;
            res.event_kind = KIND_CMD_POSTED;
        end
        else if (item.entry_control[0] != ring_cycle)
        begin
            // producer has not written this slot yet
            res.event_kind = KIND_NOT_OWNED;
        end
        else
        begin
            res.owned = 1'b1;
            if (ring_head + 1 >= RING_SIZE)
            begin
                ring_head  = 0;
                ring_cycle = ~ring_cycle;
            end
            else
            begin
                ring_head++;
            end
            if (etype == TYPE_CMD_DONE)
            begin
                // a zero pending address means no command is outstanding
                if (ring_pending == '0 || item.entry_parameter != ring_pending)
                begin
                    ring_online    = 1'b0;
                    res.event_kind = KIND_CMD_MISMATCH;
                end
                else
                begin
                    ring_pending        = '0;
                    res.event_kind      = KIND_CMD_DONE;
                    res.completion_code = item.entry_status[31:24];
                    res.slot_number     = item.entry_control[31:24];
                end
            end
            else if (etype == TYPE_TRANSFER)
            begin
                res.event_kind          = KIND_TRANSFER;
                res.forwarded_parameter = item.entry_parameter;
                res.forwarded_status    = item.entry_status;
            end
            else if (etype == TYPE_PORT)
            begin
                res.port_number = port;
                if (port == 8'd0 || port > ring_ports)
                begin
                    ring_online    = 1'b0;
                    res.event_kind = KIND_BAD_PORT;
                end
                else
                begin
                    res.event_kind = KIND_PORT;
                end
            end
            else if (etype == TYPE_HOST_ERR)
            begin
                ring_online    = 1'b0;
                res.event_kind = KIND_HOST_ERROR;
            end
            else
            begin
                res.event_kind = KIND_IGNORED;
            end
        end
        res.dequeue_index  = ring_head[7:0];
        res.consumer_cycle = ring_cycle;
        res.online_flag    = ring_online;
        return res;
    endfunction

    function automatic logic [31:0] ctrl_word(input logic [5:0] etype, input logic cyc,
                                              input logic [7:0] slot);
        return {slot, 8'h00, etype, 9'h000, cyc};
    endfunction

    function automatic in_item_t entry_item(input logic [63:0] param,
                                            input logic [31:0] status,
                                            input logic [31:0] control);
        in_item_t item;
        item                 = '0;
        item.mode            = MODE_ENTRY;
        item.entry_parameter = param;
        item.entry_status    = status;
        item.entry_control   = control;
        item.posted_command  = {$urandom, $urandom};
        return item;
    endfunction

    function automatic in_item_t post_item(input logic [63:0] addr);
        in_item_t item;
        item                 = '0;
        item.mode            = MODE_POST;
        item.entry_parameter = {$urandom, $urandom};
        item.entry_status    = $urandom;
        item.entry_control   = $urandom;
        item.posted_command  = addr;
        return item;
    endfunction

    // Build a beat of the requested shape with random filler, using the mirrored state
    // so that owned entries carry the right cycle bit and completions the right address.
    function automatic in_item_t make_entry(input entry_pick_t pick);
        in_item_t    item;
        entry_pick_t sel;
        logic [5:0]  etype;
        item.mode            = MODE_ENTRY;
        item.entry_parameter = {$urandom, $urandom};
        item.entry_status    = $urandom;
        item.entry_control   = $urandom;
        item.posted_command  = {$urandom, $urandom};
        sel = pick;
        // fall back where the wanted shape would be fatal
        if (sel == GEN_DONE && ring_pending == '0)
            sel = GEN_POST;
        if (sel == GEN_PORT && ring_ports == 8'd0)
            sel = GEN_OTHER;
        etype = item.entry_control[15:10];
        case (sel)
            GEN_POST:
            begin
                item.mode = MODE_POST;
                if ($urandom_range(15) == 0)
                    item.posted_command = '0;
            end
            GEN_DONE:
            begin
                etype                = TYPE_CMD_DONE;
                item.entry_parameter = ring_pending;
            end
            GEN_TRANSFER:
                etype = TYPE_TRANSFER;
            GEN_PORT:
            begin
                etype                       = TYPE_PORT;
                item.entry_parameter[31:24] = 8'($urandom_range(ring_ports, 1));
            end
            GEN_OTHER:
            begin
                while (etype == TYPE_TRANSFER || etype == TYPE_CMD_DONE ||
                       etype == TYPE_PORT || etype == TYPE_HOST_ERR)
                    etype = 6'($urandom_range(63));
            end
            default:
                ;
        endcase
        item.entry_control[15:10] = etype;
        item.entry_control[0]     = (sel == GEN_STALE) ? ~ring_cycle : ring_cycle;
        return item;
    endfunction

    function automatic entry_pick_t weighted_pick();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15)
            return GEN_POST;
        if (r < 35)
            return GEN_DONE;
        if (r < 55)
            return GEN_TRANSFER;
        if (r < 70)
            return GEN_PORT;
        if (r < 85)
            return GEN_OTHER;
        return GEN_STALE;
    endfunction

    // Present one input beat, hold it until the block takes it, then predict its result.
    // Valid is left high on return so back-to-back beats need no extra edge.
    task automatic send_beat(input in_item_t item);
        while (!steady && $urandom_range(99) < STALL_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted_events.push_back(classify_entry(item));
        beats_in++;
    endtask

    // Drop valid and wait for every owed result, plus the pipeline depth.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (predicted_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TICKS)
            @(posedge clk);
    endtask

    task automatic write_port_count(input logic [7:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        ring_ports = value;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Field extremes, stale, transfer, ignored, posted and completion events, and command
    // address handling, all with port_count still at its reset value of zero.
    task automatic test_directed_basics();
        logic [63:0] addr;
        // stale slot: cycle bit does not match, even for a host error type
        send_beat(entry_item('1, '1, ctrl_word(TYPE_TRANSFER, ~ring_cycle, 8'hFF)));
        send_beat(entry_item('0, '0, ctrl_word(TYPE_HOST_ERR, ~ring_cycle, 8'h00)));
        // transfers at both extremes of the forwarded words
        send_beat(entry_item('1, '1, ctrl_word(TYPE_TRANSFER, ring_cycle, 8'hFF)));
        send_beat(entry_item('0, '0, ctrl_word(TYPE_TRANSFER, ring_cycle, 8'h00)));
        // types the block does not handle are consumed and ignored
        send_beat(entry_item('0, '0, ctrl_word(6'd0, ring_cycle, 8'h00)));
        send_beat(entry_item('1, '1, {31'h7FFF_FFFF, ring_cycle}));
        // command completions with completion code and slot at their extremes
        send_beat(post_item('1));
        send_beat(entry_item('1, 32'hFF00_0000, ctrl_word(TYPE_CMD_DONE, ring_cycle, 8'hFF)));
        send_beat(post_item(64'd1));
        send_beat(entry_item(64'd1, 32'h00FF_FFFF, ctrl_word(TYPE_CMD_DONE, ring_cycle, 8'h00)));
        // posting zero leaves nothing pending
        send_beat(post_item('0));
        // a second post replaces the first
        send_beat(post_item({$urandom, $urandom} | 64'h1));
        addr = {$urandom, $urandom} | 64'h1;
        send_beat(post_item(addr));
        // a stale completion with the wrong address must not count
        send_beat(entry_item(~addr, '1, ctrl_word(TYPE_CMD_DONE, ~ring_cycle, 8'h5A)));
        send_beat(entry_item(addr, $urandom, ctrl_word(TYPE_CMD_DONE, ring_cycle, 8'hA5)));
    endtask

    // Port change events at the edges of the configured range.
    task automatic test_port_range();
        in_item_t item;
        write_port_count(8'd255);
        item = make_entry(GEN_PORT);
        item.entry_parameter[31:24] = 8'd255;
        send_beat(item);
        item = make_entry(GEN_PORT);
        item.entry_parameter[31:24] = 8'd1;
        send_beat(item);
        write_port_count(8'd1);
        item = make_entry(GEN_PORT);
        item.entry_parameter[31:24] = 8'd1;
        send_beat(item);
    endtask

    // Back-to-back owned entries and posts with no hold-off on either side, long enough to
    // wrap the head and flip the cycle bit.
    task automatic test_ring_wrap(input int unsigned beats);
        write_port_count(8'($urandom_range(255, 1)));
        steady = 1'b1;
        repeat (beats)
            send_beat(make_entry(entry_pick_t'($urandom_range(GEN_OTHER))));
        steady = 1'b0;
    endtask

    // Mostly well-formed traffic with random content, plus stale slots, under one setting.
    task automatic test_random_mix(input logic [7:0] ports, input int unsigned beats);
        write_port_count(ports);
        repeat (beats)
            send_beat(make_entry(weighted_pick()));
    endtask

    // Take the block offline one way, then check that nothing moves afterwards.
    task automatic test_fatal_then_offline();
        in_item_t    item;
        fatal_pick_t pick;
        write_port_count(8'($urandom_range(254)));
        pick = fatal_pick_t'($urandom_range(FATAL_HOST_ERROR));
        item = make_entry(GEN_TRANSFER);
        case (pick)
            FATAL_ADDR_MISMATCH:
            begin
                send_beat(post_item({$urandom, $urandom} | 64'h1));
                item.entry_parameter      = ring_pending ^ ({$urandom, $urandom} | 64'h1);
                item.entry_control[15:10] = TYPE_CMD_DONE;
            end
            FATAL_NO_COMMAND:
            begin
                send_beat(post_item('0));
                item.entry_control[15:10] = TYPE_CMD_DONE;
            end
            FATAL_PORT_ZERO:
            begin
                item.entry_parameter[31:24] = 8'd0;
                item.entry_control[15:10]   = TYPE_PORT;
            end
            FATAL_PORT_ABOVE:
            begin
                item.entry_parameter[31:24] = 8'($urandom_range(255, ring_ports + 1));
                item.entry_control[15:10]   = TYPE_PORT;
            end
            default:
                item.entry_control[15:10] = TYPE_HOST_ERR;
        endcase
        item.entry_control[0] = ring_cycle;
        send_beat(item);
        repeat (10)
            send_beat(make_entry(weighted_pick()));
    endtask

    // Result side: hold off at random, except during the steady stretch.
    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= STALL_PCT);
    end

    // Compare every result beat with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beats_out++;
            if (predicted_events.size() == 0)
            begin
                $error("result beat with no prediction pending, kind %0d",
                       out_data.event_kind);
                mismatch_count++;
            end
            else
            begin
                want = predicted_events.pop_front();
                check_field("owned", want.owned, out_data.owned);
                check_field("event_kind", want.event_kind, out_data.event_kind);
                check_field("completion_code", want.completion_code,
                            out_data.completion_code);
                check_field("slot_number", want.slot_number, out_data.slot_number);
                check_field("port_number", want.port_number, out_data.port_number);
                check_field("forwarded_parameter", want.forwarded_parameter,
                            out_data.forwarded_parameter);
                check_field("forwarded_status", want.forwarded_status,
                            out_data.forwarded_status);
                check_field("dequeue_index", want.dequeue_index, out_data.dequeue_index);
                check_field("consumer_cycle", want.consumer_cycle, out_data.consumer_cycle);
                check_field("online_flag", want.online_flag, out_data.online_flag);
            end
            if (int'(out_data.event_kind) < 10)
                kind_tally[int'(out_data.event_kind)]++;
        end
    end

    // Hang detector: count cycles in which no channel moves a beat.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: %0d cycles without a beat, %0d results owed",
                     idle_cycles, predicted_events.size());
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        // mirror the reset state of the block
        ring_head    = 0;
        ring_cycle   = 1'b1;
        ring_pending = '0;
        ring_online  = 1'b1;
        ring_ports   = 8'd0;

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        test_directed_basics();
        test_port_range();
        test_ring_wrap(400);
        test_random_mix(8'd0, 85);
        test_random_mix(8'd255, 85);
        test_random_mix(8'($urandom_range(254, 1)), 85);
        test_random_mix(8'd1, 65);
        test_fatal_then_offline();
        drain_results();

        $display("Sent %0d input beats, checked %0d results; port_count 0, 1, 255 and random.",
                 beats_in, beats_out);
        $write("Kinds seen: stale %0d, done %0d, transfer %0d, port %0d, ",
               kind_tally[KIND_NOT_OWNED], kind_tally[KIND_CMD_DONE],
               kind_tally[KIND_TRANSFER], kind_tally[KIND_PORT]);
        $display("ignored %0d, fatal %0d, offline %0d, posted %0d",
                 kind_tally[KIND_IGNORED],
                 kind_tally[KIND_CMD_MISMATCH] + kind_tally[KIND_BAD_PORT] +
                 kind_tally[KIND_HOST_ERROR],
                 kind_tally[KIND_OFFLINE], kind_tally[KIND_CMD_POSTED]);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
